// ===== design/acc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the aging contact cache: sizes, op codes, table entry type,
// controller states and the vertex counter index function. No dependencies.
package acc_pkg;

  localparam int TABLE_SLOTS      = 1024;
  localparam int STRAND_COUNT     = 64;
  localparam int VERTS_PER_STRAND = 64;
  localparam int TBL_AW           = $clog2(TABLE_SLOTS);
  localparam int FILL_W           = TBL_AW + 1;
  localparam int CNT_DEPTH        = (STRAND_COUNT + 1) * VERTS_PER_STRAND;
  localparam int CNT_AW           = $clog2(CNT_DEPTH);
  localparam int CNT_W            = 11;
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
  localparam logic [3:0] MAX_AGE_RST = 4'd3;
  localparam logic signed [6:0] STRAND_MESH = -7'sd1;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_CONN   = 3'd2,
    OP_COUNT  = 3'd3,
    OP_AGE    = 3'd4
  } op_t;

  typedef struct packed {
    logic [25:0] key;
    logic [3:0]  age;
    logic        first;
    logic [31:0] handle;
  } tbl_entry_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_CNT_RD, ST_CNT_DT, ST_LK_RD, ST_LK_CMP, ST_MISS,
    ST_AG_RD, ST_AG_EV, ST_AG_CA_RD, ST_AG_CA, ST_AG_CB_RD, ST_AG_CB, ST_AG_DONE
  } state_t;

  // Counter index (strand+1)*64 + vertex; every 7-bit strand is below 64,
  // so only strands under the mesh code fall out of range.
  function automatic logic [CNT_AW:0] cnt_index(logic [6:0] strand, logic [5:0] vertex);
    logic [6:0] s1;
    logic       ok;
    s1 = strand + 7'd1;
    ok = (strand[6] == 1'b0) || (strand == STRAND_MESH);
    return {ok, s1, vertex};
  endfunction

endpackage

// ===== design/aging_contact_cache_top.sv =====
`timescale 1ns / 1ps
// Top level of the aging contact cache: control, entry table memory and
// vertex counter memory. Depends on acc_pkg.
//
//  channel   ports                               handshake
//  request   start, busy, in_op .. in_payload    taken when start & !busy
//  result    out_valid, out_hit .. out_remaining one-cycle strobe, no stall
//  config    cfg_we, cfg_data                    written when cfg_we
//
// After reset the 4160 counters are swept to zero with busy high. Insert,
// find and connected scan the filled slots through the table read port,
// a read state and a compare state per slot: a miss passes through ST_MISS
// before it answers; a hit answers from the compare of the matching slot.
// Count query reads the counter and answers; an unknown op answers from
// idle, with busy staying low. Age all sweeps the 4160 counters, then walks
// the table: a read and an evaluate state per entry, two counter updates
// more for an entry at full age, and a final state to report. Results
// cannot be held off; busy stays high until the result strobe.
module aging_contact_cache_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_op,
  input  logic signed [6:0]     in_strand_a,
  input  logic [5:0]            in_vertex_a,
  input  logic signed [6:0]     in_strand_b,
  input  logic [5:0]            in_vertex_b,
  input  logic [31:0]           in_payload,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [31:0]           out_payload_out,
  output logic [10:0]           out_contact_count,
  output logic                  out_overflow,
  output logic [10:0]           out_erased_total,
  output logic [10:0]           out_remaining_total,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_data
);
  import acc_pkg::*;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   idx_r, idx_nxt, wr_r, wr_nxt, fill_r, fill_nxt;
  logic [FILL_W-1:0]   erased_r, erased_nxt, remain_r, remain_nxt;
  logic [CNT_AW-1:0]   clr_r, clr_nxt;
  logic                ag_flag_r, ag_flag_nxt;
  logic [3:0]          max_age_r;
  logic [2:0]          op_r, op_nxt;
  logic [25:0]         key_r, key_nxt, ent_key_r, ent_key_nxt;
  logic [31:0]         pl_r, pl_nxt;
  logic [CNT_AW:0]     cix_r, cix_nxt;

  logic                accept;
  logic                swap;
  logic [25:0]         in_key, conn_key;
  logic [CNT_AW:0]     ia, ib;
  logic                idx_last;

  tbl_entry_t          tbl_mem [TABLE_SLOTS];
  tbl_entry_t          tbl_q, tbl_wdata;
  logic                tbl_we;
  logic [TBL_AW-1:0]   tbl_waddr;
  logic [CNT_W-1:0]    cnt_mem [CNT_DEPTH];
  logic [CNT_W-1:0]    cnt_q, cnt_wdata;
  logic                cnt_we;
  logic [CNT_AW-1:0]   cnt_raddr, cnt_waddr;

  logic                ov_nxt, ohit_nxt, oovf_nxt;
  logic [31:0]         opl_nxt;
  logic [10:0]         ocnt_nxt, oer_nxt, orem_nxt;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_key   = {in_strand_a, in_vertex_a, in_strand_b, in_vertex_b};
  assign swap     = (in_strand_a == STRAND_MESH) ||
                    ((in_strand_b != STRAND_MESH) && (in_strand_b < in_strand_a));
  assign conn_key = swap ? {in_strand_b, in_vertex_b, in_strand_a, in_vertex_a} : in_key;
  assign ia       = cnt_index(ent_key_r[25:19], ent_key_r[18:13]);
  assign ib       = cnt_index(ent_key_r[12:6], ent_key_r[5:0]);
  assign idx_last = (idx_r + FILL_W'(1)) >= fill_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_r == CNT_AW'(CNT_DEPTH - 1)) begin
          if (!ag_flag_r) state_nxt = ST_IDLE;
          else if (fill_r == '0) state_nxt = ST_AG_DONE;
          else state_nxt = ST_AG_RD;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_INSERT, OP_FIND, OP_CONN: state_nxt = (fill_r == '0) ? ST_MISS : ST_LK_RD;
            OP_COUNT: state_nxt = ST_CNT_RD;
            OP_AGE:   state_nxt = ST_CLR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD: state_nxt = ST_CNT_DT;
      ST_CNT_DT: state_nxt = ST_IDLE;
      ST_LK_RD:  state_nxt = ST_LK_CMP;
      ST_LK_CMP: begin
        if (tbl_q.key == key_r) state_nxt = ST_IDLE;
        else if (idx_last) state_nxt = ST_MISS;
        else state_nxt = ST_LK_RD;
      end
      ST_MISS:   state_nxt = ST_IDLE;
      ST_AG_RD:  state_nxt = ST_AG_EV;
      ST_AG_EV: begin
        if (tbl_q.age == max_age_r) state_nxt = ST_AG_CA_RD;
        else if (idx_last) state_nxt = ST_AG_DONE;
        else state_nxt = ST_AG_RD;
      end
      ST_AG_CA_RD: state_nxt = ST_AG_CA;
      ST_AG_CA:    state_nxt = ST_AG_CB_RD;
      ST_AG_CB_RD: state_nxt = ST_AG_CB;
      ST_AG_CB:    state_nxt = idx_last ? ST_AG_DONE : ST_AG_RD;
      ST_AG_DONE:  state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result values
  always_comb begin
    idx_nxt     = idx_r;
    wr_nxt      = wr_r;
    fill_nxt    = fill_r;
    erased_nxt  = erased_r;
    remain_nxt  = remain_r;
    clr_nxt     = clr_r;
    ag_flag_nxt = ag_flag_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    pl_nxt      = pl_r;
    cix_nxt     = cix_r;
    ent_key_nxt = ent_key_r;
    tbl_we      = 1'b0;
    tbl_waddr   = idx_r[TBL_AW-1:0];
    tbl_wdata   = tbl_q;
    cnt_we      = 1'b0;
    cnt_waddr   = clr_r;
    cnt_wdata   = '0;
    cnt_raddr   = cix_r[CNT_AW-1:0];
    ov_nxt      = 1'b0;
    ohit_nxt    = 1'b0;
    opl_nxt     = '0;
    ocnt_nxt    = '0;
    oovf_nxt    = 1'b0;
    oer_nxt     = '0;
    orem_nxt    = '0;
    case (state_r)
      ST_CLR: begin
        // zero one counter per cycle
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        clr_nxt   = clr_r + CNT_AW'(1);
        if (clr_r == CNT_AW'(CNT_DEPTH - 1)) begin
          clr_nxt    = '0;
          idx_nxt    = '0;
          wr_nxt     = '0;
          erased_nxt = '0;
          remain_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          // capture the request
          op_nxt  = in_op;
          key_nxt = (in_op == OP_CONN) ? conn_key : in_key;
          pl_nxt  = in_payload;
          cix_nxt = cnt_index(in_strand_a, in_vertex_a);
          idx_nxt = '0;
          if (in_op == OP_AGE) begin
            ag_flag_nxt = 1'b1;
            clr_nxt     = '0;
          end
          if (!(in_op inside {OP_INSERT, OP_FIND, OP_CONN, OP_COUNT, OP_AGE})) begin
            ov_nxt = 1'b1;
          end
        end
      end
      ST_CNT_DT: begin
        ov_nxt   = 1'b1;
        ocnt_nxt = cix_r[CNT_AW] ? cnt_q : '0;
      end
      ST_LK_CMP: begin
        if (tbl_q.key == key_r) begin
          ov_nxt = 1'b1;
          case (op_r)
            OP_INSERT: begin
              // refresh the entry
              tbl_we    = 1'b1;
              tbl_wdata = '{key: key_r, age: max_age_r, first: 1'b0, handle: pl_r};
            end
            OP_FIND: begin
              ohit_nxt = !tbl_q.first;
              opl_nxt  = tbl_q.first ? 32'd0 : tbl_q.handle;
            end
            OP_CONN:  ohit_nxt = (tbl_q.age == (max_age_r - 4'd1));
            default:  ohit_nxt = 1'b0;
          endcase
        end else begin
          idx_nxt = idx_r + FILL_W'(1);
        end
      end
      ST_MISS: begin
        ov_nxt = 1'b1;
        if (op_r == OP_INSERT) begin
          if (fill_r < FILL_W'(TABLE_SLOTS)) begin
            // append at the end of the packed table
            tbl_we    = 1'b1;
            tbl_waddr = fill_r[TBL_AW-1:0];
            tbl_wdata = '{key: key_r, age: max_age_r, first: 1'b1, handle: pl_r};
            fill_nxt  = fill_r + FILL_W'(1);
          end else begin
            oovf_nxt = 1'b1;
          end
        end
      end
      ST_AG_EV: begin
        // age the entry, compacting survivors towards slot zero
        ent_key_nxt = tbl_q.key;
        if (tbl_q.age <= 4'd1) begin
          erased_nxt = erased_r + FILL_W'(1);
        end else begin
          tbl_we     = 1'b1;
          tbl_waddr  = wr_r[TBL_AW-1:0];
          tbl_wdata  = tbl_q;
          tbl_wdata.age = tbl_q.age - 4'd1;
          wr_nxt     = wr_r + FILL_W'(1);
          remain_nxt = remain_r + FILL_W'(1);
        end
        if (tbl_q.age != max_age_r) idx_nxt = idx_r + FILL_W'(1);
      end
      ST_AG_CA_RD: cnt_raddr = ia[CNT_AW-1:0];
      ST_AG_CA: begin
        cnt_raddr = ia[CNT_AW-1:0];
        cnt_waddr = ia[CNT_AW-1:0];
        cnt_wdata = cnt_q + CNT_W'(1);
        cnt_we    = ia[CNT_AW] && (cnt_q != CNT_SAT);
      end
      ST_AG_CB_RD: cnt_raddr = ib[CNT_AW-1:0];
      ST_AG_CB: begin
        cnt_raddr = ib[CNT_AW-1:0];
        cnt_waddr = ib[CNT_AW-1:0];
        cnt_wdata = cnt_q + CNT_W'(1);
        cnt_we    = ib[CNT_AW] && (cnt_q != CNT_SAT);
        idx_nxt   = idx_r + FILL_W'(1);
      end
      ST_AG_DONE: begin
        ov_nxt      = 1'b1;
        fill_nxt    = wr_r;
        ag_flag_nxt = 1'b0;
        oer_nxt     = 11'(erased_r);
        orem_nxt    = 11'(remain_r);
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_r     <= '0;
      fill_r    <= '0;
      ag_flag_r <= 1'b0;
      max_age_r <= MAX_AGE_RST;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      fill_r    <= fill_nxt;
      ag_flag_r <= ag_flag_nxt;
      out_valid <= ov_nxt;
      if (cfg_we) max_age_r <= cfg_data;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    idx_r               <= idx_nxt;
    wr_r                <= wr_nxt;
    erased_r            <= erased_nxt;
    remain_r            <= remain_nxt;
    op_r                <= op_nxt;
    key_r               <= key_nxt;
    pl_r                <= pl_nxt;
    cix_r               <= cix_nxt;
    ent_key_r           <= ent_key_nxt;
    out_hit             <= ohit_nxt;
    out_payload_out     <= opl_nxt;
    out_contact_count   <= ocnt_nxt;
    out_overflow        <= oovf_nxt;
    out_erased_total    <= oer_nxt;
    out_remaining_total <= orem_nxt;
  end

  // Entry table memory
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_q <= tbl_mem[idx_r[TBL_AW-1:0]];
  end

  // Vertex counter memory
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[cnt_raddr];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TABLE_SLOTS)) else $error("fill count beyond table size");
  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LK_CMP || state_r == ST_AG_EV) |-> idx_r < fill_r)
    else $error("scan index past filled slots");
  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> out_valid && !out_hit) else $error("overflow with hit");
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AG_EV) |-> wr_r <= idx_r) else $error("compaction overtakes scan");
endmodule
